### sv/dpf_pkg.sv
// ----------------------------------------------------------------------------
// dpf_pkg
// Shared widths, defaults and register indexes of the persistence filter.
// ----------------------------------------------------------------------------
package dpf_pkg;

    localparam int COORD_W    = 12;    // port width of a rectangle field
    localparam int TIME_W     = 32;
    localparam int OVL_W      = 7;
    localparam int HOLD_W     = 8;
    localparam int CFG_DATA_W = 8;
    localparam int CFG_IDX_W  = 1;

    localparam int MAX_RECTS_DEF  = 64;
    localparam int COORD_BITS_DEF = 12;

    localparam logic [OVL_W-1:0]  OVL_RESET  = 7'd80;
    localparam logic [HOLD_W-1:0] HOLD_RESET = 8'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OVERLAP = 1'b0,
        REG_HOLD    = 1'b1
    } cfg_reg_t;

endpackage

### sv/dpf_if.sv
// ----------------------------------------------------------------------------
// dpf_in_if / dpf_out_if
// Valid/ready channels for detection items and filtered results.
// ----------------------------------------------------------------------------
interface dpf_in_if;
    logic                        valid;
    logic                        ready;
    logic                        empty_frame;
    logic [dpf_pkg::COORD_W-1:0] rect_x;
    logic [dpf_pkg::COORD_W-1:0] rect_y;
    logic [dpf_pkg::COORD_W-1:0] rect_w;
    logic [dpf_pkg::COORD_W-1:0] rect_h;
    logic [dpf_pkg::TIME_W-1:0]  now_time;
    logic                        frame_end;

    modport source (output valid, empty_frame, rect_x, rect_y, rect_w, rect_h,
                    now_time, frame_end, input ready);
    modport sink   (input valid, empty_frame, rect_x, rect_y, rect_w, rect_h,
                    now_time, frame_end, output ready);
endinterface

interface dpf_out_if;
    logic                        valid;
    logic                        ready;
    logic                        is_stable;
    logic [dpf_pkg::COORD_W-1:0] out_x;
    logic [dpf_pkg::COORD_W-1:0] out_y;
    logic [dpf_pkg::COORD_W-1:0] out_w;
    logic [dpf_pkg::COORD_W-1:0] out_h;
    logic [dpf_pkg::TIME_W-1:0]  first_seen;
    logic                        table_full;

    modport source (output valid, is_stable, out_x, out_y, out_w, out_h,
                    first_seen, table_full, input ready);
    modport sink   (input valid, is_stable, out_x, out_y, out_w, out_h,
                    first_seen, table_full, output ready);
endinterface

### sv/dpf_ram.sv
// ----------------------------------------------------------------------------
// dpf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

### sv/dpf_front.sv
// ----------------------------------------------------------------------------
// dpf_front
// Accept items, mask coordinates, compute area and queue them (two deep).
// ----------------------------------------------------------------------------
module dpf_front #(
    parameter int CB = dpf_pkg::COORD_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    dpf_in_if.sink                     in_ch,
    output logic                       q_valid,
    input  logic                       q_pop,
    output logic                       q_empty,
    output logic                       q_fe,
    output logic [CB-1:0]              q_x,
    output logic [CB-1:0]              q_y,
    output logic [CB-1:0]              q_w,
    output logic [CB-1:0]              q_h,
    output logic [2*CB-1:0]            q_area,
    output logic [dpf_pkg::TIME_W-1:0] q_now
);
    import dpf_pkg::*;

    logic            e_empty [2];
    logic            e_fe    [2];
    logic [CB-1:0]   e_x     [2];
    logic [CB-1:0]   e_y     [2];
    logic [CB-1:0]   e_w     [2];
    logic [CB-1:0]   e_h     [2];
    logic [2*CB-1:0] e_area  [2];
    logic [TIME_W-1:0] e_now [2];

    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push;
    logic [CB-1:0] mw, mh;

    assign in_ch.ready = (cnt_reg != 2'd2);
    assign push        = in_ch.valid && in_ch.ready;
    assign mw          = CB'(in_ch.rect_w);
    assign mh          = CB'(in_ch.rect_h);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            e_empty[wr_ptr_reg] <= in_ch.empty_frame;
            e_fe[wr_ptr_reg]    <= in_ch.frame_end;
            e_x[wr_ptr_reg]     <= CB'(in_ch.rect_x);
            e_y[wr_ptr_reg]     <= CB'(in_ch.rect_y);
            e_w[wr_ptr_reg]     <= mw;
            e_h[wr_ptr_reg]     <= mh;
            e_area[wr_ptr_reg]  <= mw * mh;
            e_now[wr_ptr_reg]   <= in_ch.now_time;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(q_pop);
        end
    end

    assign q_valid = (cnt_reg != 2'd0);
    assign q_empty = e_empty[rd_ptr_reg];
    assign q_fe    = e_fe[rd_ptr_reg];
    assign q_x     = e_x[rd_ptr_reg];
    assign q_y     = e_y[rd_ptr_reg];
    assign q_w     = e_w[rd_ptr_reg];
    assign q_h     = e_h[rd_ptr_reg];
    assign q_area  = e_area[rd_ptr_reg];
    assign q_now   = e_now[rd_ptr_reg];
endmodule

### sv/dpf_back.sv
// ----------------------------------------------------------------------------
// dpf_back
// Scan the previous-frame table through a match pipeline, store the item in
// the current table unless it is full, and register the result. The two
// tables swap roles at frame end; an empty-frame marker clears both.
// ----------------------------------------------------------------------------
module dpf_back #(
    parameter int MAX_RECTS = dpf_pkg::MAX_RECTS_DEF,
    parameter int CB        = dpf_pkg::COORD_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [dpf_pkg::OVL_W-1:0]  overlap,
    input  logic [dpf_pkg::HOLD_W-1:0] hold,
    input  logic                       q_valid,
    output logic                       q_pop,
    input  logic                       q_empty,
    input  logic                       q_fe,
    input  logic [CB-1:0]              q_x,
    input  logic [CB-1:0]              q_y,
    input  logic [CB-1:0]              q_w,
    input  logic [CB-1:0]              q_h,
    input  logic [2*CB-1:0]            q_area,
    input  logic [dpf_pkg::TIME_W-1:0] q_now,
    dpf_out_if.source                  out_ch
);
    import dpf_pkg::*;

    localparam int AW    = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
    localparam int CNT_W = $clog2(MAX_RECTS + 1);
    localparam int RW    = 4 * CB + TIME_W;
    localparam int PW    = 2 * CB + 9;

    typedef enum logic [1:0] {ST_IDLE, ST_LOAD, ST_SCAN, ST_DONE} state_t;
    state_t state_reg;

    logic            it_empty_reg, it_fe_reg;
    logic [CB-1:0]   it_x_reg, it_y_reg, it_w_reg, it_h_reg;
    logic [2*CB-1:0] it_area_reg;
    logic [TIME_W-1:0] it_now_reg, seen_reg;
    logic [PW-1:0]   opa_reg;

    logic [CNT_W-1:0] idx_reg, cur_cnt_reg, prev_cnt_reg;
    logic             bank_reg;   // bank holding the previous frame

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic issue;

    // RAM banks
    logic [RW-1:0] rdata0, rdata1, rdata, wdata;
    logic          full, wr_ok, out_free;

    assign issue    = (state_reg == ST_SCAN) && (idx_reg != prev_cnt_reg);
    assign full     = (cur_cnt_reg == CNT_W'(MAX_RECTS));
    assign out_free = !out_ch.valid || out_ch.ready;
    assign wr_ok    = (state_reg == ST_DONE) && out_free && !it_empty_reg && !full;
    assign wdata    = {it_x_reg, it_y_reg, it_w_reg, it_h_reg, seen_reg};
    assign rdata    = bank_reg ? rdata1 : rdata0;
    assign q_pop    = (state_reg == ST_IDLE) && q_valid;

    dpf_ram #(.WIDTH(RW), .DEPTH(MAX_RECTS)) u_bank0 (
        .clk   (clk),
        .we    (wr_ok && bank_reg),
        .waddr (cur_cnt_reg[AW-1:0]),
        .wdata (wdata),
        .re    (issue),
        .raddr (idx_reg[AW-1:0]),
        .rdata (rdata0)
    );

    dpf_ram #(.WIDTH(RW), .DEPTH(MAX_RECTS)) u_bank1 (
        .clk   (clk),
        .we    (wr_ok && !bank_reg),
        .waddr (cur_cnt_reg[AW-1:0]),
        .wdata (wdata),
        .re    (issue),
        .raddr (idx_reg[AW-1:0]),
        .rdata (rdata1)
    );

    // Stage 2: intersection extents and area of the stored rectangle
    logic [CB-1:0]   bx, by, bw, bh;
    logic [TIME_W-1:0] bt;
    logic [CB:0]     ax2, ay2, bx2, by2, x1, y1, x2, y2;
    logic            ovl;

    assign {bx, by, bw, bh, bt} = rdata;
    assign ax2 = {1'b0, it_x_reg} + {1'b0, it_w_reg};
    assign ay2 = {1'b0, it_y_reg} + {1'b0, it_h_reg};
    assign bx2 = {1'b0, bx} + {1'b0, bw};
    assign by2 = {1'b0, by} + {1'b0, bh};
    assign x1  = (it_x_reg > bx) ? {1'b0, it_x_reg} : {1'b0, bx};
    assign y1  = (it_y_reg > by) ? {1'b0, it_y_reg} : {1'b0, by};
    assign x2  = (ax2 < bx2) ? ax2 : bx2;
    assign y2  = (ay2 < by2) ? ay2 : by2;
    assign ovl = (x1 < x2) && (y1 < y2);

    logic            s2_ok_reg, s3_ok_reg, s4_ok_reg;
    logic [CB:0]     s2_dx_reg, s2_dy_reg;
    logic [2*CB-1:0] s2_ab_reg, s3_ab_reg;
    logic [2*CB+1:0] s3_inter_reg;
    logic [PW-1:0]   s4_i100_reg, s4_opb_reg;
    logic [TIME_W-1:0] s2_t_reg, s3_t_reg, s4_t_reg;

    always_ff @(posedge clk)
    begin
        s2_ok_reg    <= ovl;
        s2_dx_reg    <= x2 - x1;
        s2_dy_reg    <= y2 - y1;
        s2_ab_reg    <= bw * bh;
        s2_t_reg     <= bt;
        s3_ok_reg    <= s2_ok_reg;
        s3_inter_reg <= s2_dx_reg * s2_dy_reg;
        s3_ab_reg    <= s2_ab_reg;
        s3_t_reg     <= s2_t_reg;
        s4_ok_reg    <= s3_ok_reg;
        s4_i100_reg  <= PW'(s3_inter_reg) * PW'(100);
        s4_opb_reg   <= PW'(s3_ab_reg) * PW'(overlap);
        s4_t_reg     <= s3_t_reg;
    end

    logic match;
    assign match = v4_reg && s4_ok_reg && (s4_i100_reg > opa_reg)
                   && (s4_i100_reg > s4_opb_reg);

    logic stable;
    logic [TIME_W-1:0] age;
    assign age    = it_now_reg - seen_reg;
    assign stable = !it_empty_reg && (it_now_reg >= seen_reg)
                    && (age > TIME_W'(hold));

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            it_empty_reg <= q_empty;
            it_fe_reg    <= q_fe;
            it_x_reg     <= q_x;
            it_y_reg     <= q_y;
            it_w_reg     <= q_w;
            it_h_reg     <= q_h;
            it_area_reg  <= q_area;
            it_now_reg   <= q_now;
        end
        if (state_reg == ST_LOAD)
        begin
            opa_reg  <= PW'(it_area_reg) * PW'(overlap);
            seen_reg <= it_now_reg;
        end
        else if (match)
        begin
            seen_reg <= s4_t_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            idx_reg      <= '0;
            cur_cnt_reg  <= '0;
            prev_cnt_reg <= '0;
            bank_reg     <= 1'b0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            v4_reg       <= 1'b0;
            out_ch.valid <= 1'b0;
        end
        else
        begin
            v1_reg <= issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            if (out_ch.valid && out_ch.ready)
            begin
                out_ch.valid <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        state_reg <= q_empty ? ST_DONE : ST_LOAD;
                    end
                end
                ST_LOAD:
                begin
                    idx_reg   <= '0;
                    state_reg <= ST_SCAN;
                end
                ST_SCAN:
                begin
                    if (issue)
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                    else if (!v1_reg && !v2_reg && !v3_reg && !v4_reg)
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        out_ch.valid <= 1'b1;
                        state_reg    <= ST_IDLE;
                        if (it_empty_reg)
                        begin
                            cur_cnt_reg  <= '0;
                            prev_cnt_reg <= '0;
                        end
                        else if (it_fe_reg)
                        begin
                            // swap tables: current becomes previous
                            prev_cnt_reg <= full ? cur_cnt_reg : cur_cnt_reg + 1'b1;
                            cur_cnt_reg  <= '0;
                            bank_reg     <= !bank_reg;
                        end
                        else if (!full)
                        begin
                            cur_cnt_reg <= cur_cnt_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DONE && out_free)
        begin
            out_ch.is_stable  <= stable;
            out_ch.out_x      <= it_empty_reg ? '0 : COORD_W'(it_x_reg);
            out_ch.out_y      <= it_empty_reg ? '0 : COORD_W'(it_y_reg);
            out_ch.out_w      <= it_empty_reg ? '0 : COORD_W'(it_w_reg);
            out_ch.out_h      <= it_empty_reg ? '0 : COORD_W'(it_h_reg);
            out_ch.first_seen <= it_empty_reg ? '0 : seen_reg;
            out_ch.table_full <= !it_empty_reg && full;
        end
    end
endmodule

### sv/detection_persistence_filter_top.sv
// ----------------------------------------------------------------------------
// detection_persistence_filter_top
// Tracks detection rectangles across frames and flags persistent ones.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one item per rectangle (valid/ready), or an empty-frame marker.
//            frame_end on the last rectangle of a frame swaps the tables.
//   out_ch : one result per item, in order (valid/ready).
//   cfg_*  : write port for overlap_percent (index 0) and hold_seconds
//            (index 1); write only while the block is idle.
// Timing:
//   A rectangle is popped from the queue, loaded, scanned and then registered
//   as the result: the previous-frame table is read one entry per cycle
//   through the RAM read port into a four-stage match pipeline. An
//   empty-frame marker skips the scan. A new item is taken from the queue
//   only once the result of the last one has been registered.
//   A two-entry queue in front keeps taking items while a result waits.
// Reset:
//   Both tables are empty, registers return to 80 percent and 3 seconds.
//   No clearing pass is needed; stale RAM contents are never read.
// Stall:
//   The result register holds until taken; the scan of the next item runs
//   meanwhile and then waits for the register to free.
// ----------------------------------------------------------------------------
module detection_persistence_filter_top #(
    parameter int MAX_RECTS  = dpf_pkg::MAX_RECTS_DEF,
    parameter int COORD_BITS = dpf_pkg::COORD_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    dpf_in_if.sink                         in_ch,
    dpf_out_if.source                      out_ch,
    input  logic                           cfg_we,
    input  logic [dpf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dpf_pkg::CFG_DATA_W-1:0] cfg_data
);
    import dpf_pkg::*;

    logic [OVL_W-1:0]  overlap_reg;
    logic [HOLD_W-1:0] hold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            overlap_reg <= OVL_RESET;
            hold_reg    <= HOLD_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_OVERLAP: overlap_reg <= cfg_data[OVL_W-1:0];
                REG_HOLD:    hold_reg    <= cfg_data[HOLD_W-1:0];
                default:     ;
            endcase
        end
    end

    logic                    q_valid, q_pop, q_empty, q_fe;
    logic [COORD_BITS-1:0]   q_x, q_y, q_w, q_h;
    logic [2*COORD_BITS-1:0] q_area;
    logic [TIME_W-1:0]       q_now;

    dpf_front #(.CB(COORD_BITS)) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_empty (q_empty),
        .q_fe    (q_fe),
        .q_x     (q_x),
        .q_y     (q_y),
        .q_w     (q_w),
        .q_h     (q_h),
        .q_area  (q_area),
        .q_now   (q_now)
    );

    dpf_back #(.MAX_RECTS(MAX_RECTS), .CB(COORD_BITS)) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .overlap (overlap_reg),
        .hold    (hold_reg),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_empty (q_empty),
        .q_fe    (q_fe),
        .q_x     (q_x),
        .q_y     (q_y),
        .q_w     (q_w),
        .q_h     (q_h),
        .q_area  (q_area),
        .q_now   (q_now),
        .out_ch  (out_ch)
    );
endmodule

### bench/tb_detection_persistence_filter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_detection_persistence_filter_top
// Drives frames of rectangles and empty-frame markers into the filter and
// checks every result against a behavioral copy of the two-table tracker.
// ----------------------------------------------------------------------------
module tb_detection_persistence_filter_top;
    import dpf_pkg::*;

    localparam int NRECT = MAX_RECTS_DEF;

    typedef struct packed {
        logic        empty_frame;
        logic [11:0] x;
        logic [11:0] y;
        logic [11:0] w;
        logic [11:0] h;
        logic [31:0] now;
        logic        frame_end;
    } det_t;

    typedef struct packed {
        logic        is_stable;
        logic [11:0] x;
        logic [11:0] y;
        logic [11:0] w;
        logic [11:0] h;
        logic [31:0] first_seen;
        logic        table_full;
    } trk_t;

    typedef struct packed {
        logic [11:0] x;
        logic [11:0] y;
        logic [11:0] w;
        logic [11:0] h;
    } box_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    dpf_in_if  in_ch ();
    dpf_out_if out_ch ();

    detection_persistence_filter_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch.sink),
        .out_ch    (out_ch.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predictor state
    box_t        old_box [NRECT];
    logic [31:0] old_seen [NRECT];
    int          old_cnt;
    box_t        new_box [NRECT];
    logic [31:0] new_seen [NRECT];
    int          new_cnt;
    logic [6:0]  ovl_pct;
    logic [7:0]  hold_s;

    trk_t tracks_due [$];
    trk_t last_pred;
    int   errors;
    bit   calm;
    int   sent;

    // Directed stimulus table
    det_t rows [$];
    trk_t rows_want [$];
    bit   rows_known [$];

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic bit boxes_overlap(box_t a, box_t b);
        longint unsigned x1, y1, x2, y2, ax2, ay2, bx2, by2, inter, aa, ab;
        ax2 = longint'(a.x) + a.w;
        ay2 = longint'(a.y) + a.h;
        bx2 = longint'(b.x) + b.w;
        by2 = longint'(b.y) + b.h;
        x1 = (a.x > b.x) ? a.x : b.x;
        y1 = (a.y > b.y) ? a.y : b.y;
        x2 = (ax2 < bx2) ? ax2 : bx2;
        y2 = (ay2 < by2) ? ay2 : by2;
        if (!(x1 < x2 && y1 < y2))
            return 0;
        inter = (x2 - x1) * (y2 - y1);
        aa = longint'(a.w) * a.h;
        ab = longint'(b.w) * b.h;
        return (inter * 100 > ovl_pct * aa) && (inter * 100 > ovl_pct * ab);
    endfunction

    function automatic trk_t track_det(det_t d);
        trk_t t;
        box_t r;
        logic [31:0] seen;
        t = '0;
        if (d.empty_frame)
        begin
            old_cnt = 0;
            new_cnt = 0;
            return t;
        end
        r = '{d.x, d.y, d.w, d.h};
        seen = d.now;
        for (int i = 0; i < old_cnt; i++)
            if (boxes_overlap(r, old_box[i]))
                seen = old_seen[i];
        if (new_cnt < NRECT)
        begin
            new_box[new_cnt] = r;
            new_seen[new_cnt] = seen;
            new_cnt++;
        end
        else
            t.table_full = 1'b1;
        t.is_stable = (d.now >= seen) && ((d.now - seen) > hold_s);
        if (d.frame_end)
        begin
            for (int i = 0; i < new_cnt; i++)
            begin
                old_box[i] = new_box[i];
                old_seen[i] = new_seen[i];
            end
            old_cnt = new_cnt;
            new_cnt = 0;
        end
        t.x = d.x;
        t.y = d.y;
        t.w = d.w;
        t.h = d.h;
        t.first_seen = seen;
        return t;
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    task automatic add_row(det_t d, trk_t w, bit known);
        rows.insert(rows.size(), d);
        rows_want.insert(rows_want.size(), w);
        rows_known.insert(rows_known.size(), known);
    endtask

    task automatic send_det(det_t d);
        int gap;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 17);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.empty_frame <= d.empty_frame;
        in_ch.rect_x      <= d.x;
        in_ch.rect_y      <= d.y;
        in_ch.rect_w      <= d.w;
        in_ch.rect_h      <= d.h;
        in_ch.now_time    <= d.now;
        in_ch.frame_end   <= d.frame_end;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        last_pred = track_det(d);
        tracks_due.insert(tracks_due.size(), last_pred);
        sent++;
    endtask

    task automatic send_checked(det_t d, trk_t want);
        send_det(d);
        if (last_pred !== want)
            report("directed row", 64'(last_pred), 64'(want));
    endtask

    task automatic wait_drain();
        in_ch.valid <= 1'b0;
        while (tracks_due.size() != 0)
            @(posedge clk);
        repeat (NRECT + 20) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [7:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        if (idx == REG_OVERLAP)
            ovl_pct = val[6:0];
        else
            hold_s = val;
    endtask

    // Result side: random stalls, compare against the oldest expectation
    always @(posedge clk)
    begin
        trk_t got, want;
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                got = '{out_ch.is_stable, out_ch.out_x, out_ch.out_y, out_ch.out_w,
                        out_ch.out_h, out_ch.first_seen, out_ch.table_full};
                if (tracks_due.size() == 0)
                    report("unexpected result", 64'(got), 64'd0);
                else
                begin
                    want = tracks_due.pop_front();
                    if (got.is_stable !== want.is_stable)
                        report("is_stable", 64'(got.is_stable), 64'(want.is_stable));
                    if (got.x !== want.x) report("out_x", 64'(got.x), 64'(want.x));
                    if (got.y !== want.y) report("out_y", 64'(got.y), 64'(want.y));
                    if (got.w !== want.w) report("out_w", 64'(got.w), 64'(want.w));
                    if (got.h !== want.h) report("out_h", 64'(got.h), 64'(want.h));
                    if (got.first_seen !== want.first_seen)
                        report("first_seen", 64'(got.first_seen), 64'(want.first_seen));
                    if (got.table_full !== want.table_full)
                        report("table_full", 64'(got.table_full), 64'(want.table_full));
                end
            end
        end
    end

    initial
    begin
        int stall;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!calm && $urandom_range(0, 6) == 0)
            begin
                stall = $urandom_range(1, 17);
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
        end
    end

    function automatic det_t rand_box(logic [31:0] now, bit last, bit big);
        det_t d;
        d = '0;
        d.now = now;
        d.frame_end = last;
        if (big)
        begin
            d.x = 12'($urandom);
            d.y = 12'($urandom);
            d.w = 12'($urandom);
            d.h = 12'($urandom);
        end
        else
        begin
            d.x = 12'($urandom_range(0, 300));
            d.y = 12'($urandom_range(0, 300));
            d.w = 12'($urandom_range(0, 120));
            d.h = 12'($urandom_range(0, 120));
        end
        return d;
    endfunction

    initial
    begin
        det_t d;
        box_t track [8];
        int   nt, nfr;
        logic [31:0] clock_s;

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_OVERLAP;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.empty_frame = 1'b0;
        in_ch.rect_x = '0;
        in_ch.rect_y = '0;
        in_ch.rect_w = '0;
        in_ch.rect_h = '0;
        in_ch.now_time = '0;
        in_ch.frame_end = 1'b0;
        errors = 0;
        calm = 0;
        sent = 0;
        old_cnt = 0;
        new_cnt = 0;
        ovl_pct = OVL_RESET;
        hold_s = HOLD_RESET;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: empty marker, extremes, matches, time reversal
        add_row('{1'b1, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 32'hFFFFFFFF, 1'b1}, '0, 1);
        add_row('{1'b0, 12'd0, 12'd0, 12'd0, 12'd0, 32'd0, 1'b0},
                '{1'b0, 12'd0, 12'd0, 12'd0, 12'd0, 32'd0, 1'b0}, 1);
        add_row('{1'b0, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 32'hFFFFFFFF, 1'b1},
                '{1'b0, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 32'hFFFFFFFF, 1'b0}, 1);
        add_row('{1'b0, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 32'd10, 1'b1}, '0, 0);
        add_row('{1'b0, 12'd10, 12'd10, 12'd100, 12'd100, 32'd100, 1'b1}, '0, 0);
        add_row('{1'b0, 12'd12, 12'd11, 12'd100, 12'd100, 32'd103, 1'b0}, '0, 0);
        add_row('{1'b0, 12'd10, 12'd10, 12'd0, 12'd100, 32'd103, 1'b0}, '0, 0);
        add_row('{1'b0, 12'd500, 12'd500, 12'd50, 12'd50, 32'd104, 1'b1}, '0, 0);
        add_row('{1'b0, 12'd11, 12'd10, 12'd100, 12'd100, 32'd110, 1'b1}, '0, 0);
        add_row('{1'b0, 12'd11, 12'd10, 12'd100, 12'd100, 32'd50, 1'b1}, '0, 0);
        add_row('{1'b1, 12'd0, 12'd0, 12'd0, 12'd0, 32'd0, 1'b0}, '0, 1);
        foreach (rows[i])
            if (rows_known[i])
                send_checked(rows[i], rows_want[i]);
            else
                send_det(rows[i]);
        wait_drain();

        // Threshold extremes and a full table
        write_reg(REG_OVERLAP, 8'd0);
        write_reg(REG_HOLD, 8'd0);
        for (int i = 0; i <= NRECT + 2; i++)
            send_det(rand_box(32'd7, i == NRECT + 2, 0));
        for (int i = 0; i < 6; i++)
            send_det(rand_box(32'd9, i == 5, 0));
        wait_drain();
        write_reg(REG_OVERLAP, 8'd127);
        write_reg(REG_HOLD, 8'd255);
        for (int i = 0; i < 8; i++)
            send_det(rand_box(32'd400, i[0], 0));
        wait_drain();

        // Random tracks across frames, config changed per phase
        clock_s = $urandom;
        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(REG_OVERLAP, 8'($urandom_range(1, 100)));
            write_reg(REG_HOLD, (ph == 0) ? 8'd255 : 8'($urandom_range(0, 12)));
            nt = $urandom_range(1, 8);
            for (int k = 0; k < nt; k++)
            begin
                d = rand_box(0, 0, 0);
                track[k] = '{d.x, d.y, d.w, d.h};
            end
            if (ph == 5)
                calm = 1;
            for (int f = 0; f < 50 && sent < 950; f++)
            begin
                clock_s = clock_s + $urandom_range(0, 3);
                if ($urandom_range(0, 40) == 0)
                    clock_s = clock_s - $urandom_range(1, 5);
                if ($urandom_range(0, 25) == 0)
                begin
                    d = '0;
                    d.empty_frame = 1'b1;
                    d = d ^ det_t'({1'b0, 81'($urandom), ($urandom_range(0,1) == 1)});
                    send_det(d);
                    continue;
                end
                nfr = $urandom_range(1, nt + 1);
                for (int k = 0; k < nfr; k++)
                begin
                    if (k < nt && $urandom_range(0, 7) != 0)
                    begin
                        d = '0;
                        track[k].x = track[k].x + 12'($urandom_range(0, 2));
                        track[k].y = track[k].y + 12'($urandom_range(0, 2));
                        d.x = track[k].x;
                        d.y = track[k].y;
                        d.w = track[k].w;
                        d.h = track[k].h;
                        d.now = clock_s;
                        d.frame_end = (k == nfr - 1);
                    end
                    else
                        d = rand_box(clock_s, k == nfr - 1, $urandom_range(0, 3) == 0);
                    send_det(d);
                end
            end
            wait_drain();
        end

        if (errors == 0)
            $display("** detection_persistence_filter_top: PASSED **");
        else
            $display("** detection_persistence_filter_top: FAILED **");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("** detection_persistence_filter_top: FAILED **");
        $finish;
    end
endmodule
